FILE: src/ptt_pkg.sv
// Package for the periodic timer table: sizes, codes and beat types.
`default_nettype none

package ptt_pkg;

    // Table size and derived widths
    localparam int SLOTS = 8;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    // Operation codes
    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // Command beat
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  handler_id;
        logic [31:0] delay;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic [1:0] status;
        logic       fired;
        logic [7:0] fired_handler;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

FILE: src/periodic_timer_table_top.sv
// Periodic timer table: slot walker with one shared read/compare/decrement unit.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+----------------------------------------
//  command  | start, busy, cmd (cmd_t)    | beat taken at clk edge with start & !busy
//  result   | result_strobe, result       | beat valid for one cycle, always taken
//
// One slot is visited per cycle. busy drops at the edge that puts the final result
// beat on the ports; results of a tick appear while the walk goes on. The walk runs
// over the occupied slots only, paced by the single table read port and the walk
// counter. Reset (rst_n low, asynchronous) empties the table at once. The receiver
// cannot stall: every result beat is shown for exactly one cycle.
`default_nettype none

module periodic_timer_table_top
    import ptt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire cmd_t    cmd,
    output logic         result_strobe,
    output result_t      result
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_TICK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    // Table storage
    logic [7:0]  slot_handler_reg   [SLOTS];
    logic [31:0] slot_countdown_reg [SLOTS];
    logic [31:0] slot_reload_reg    [SLOTS];

    // Control registers
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    cmd_t             cmd_reg, cmd_next;
    logic [1:0]       status_reg, status_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_handler_reg, pend_handler_next;
    logic             strobe_reg, strobe_next;
    result_t          result_reg, result_next;

    // Shared read port and write port
    logic [CNT_W-1:0] idx_plus;
    logic [CNT_W-1:0] rd_idx;
    logic [7:0]       rd_handler;
    logic [31:0]      rd_countdown;
    logic [31:0]      rd_reload;
    logic             at_end;
    logic             wr_en;
    logic [7:0]       wr_handler;
    logic [31:0]      wr_countdown;
    logic [31:0]      wr_reload;

    assign idx_plus = idx_reg + 1'b1;
    assign at_end   = (idx_reg == count_reg);

    // Read one slot: the next one while compacting, else the current one
    assign rd_idx       = (state_reg == ST_SHIFT) ? idx_plus : idx_reg;
    assign rd_handler   = slot_handler_reg[rd_idx[IDX_W-1:0]];
    assign rd_countdown = slot_countdown_reg[rd_idx[IDX_W-1:0]];
    assign rd_reload    = slot_reload_reg[rd_idx[IDX_W-1:0]];

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        cmd_next          = cmd_reg;
        status_next       = status_reg;
        pend_valid_next   = pend_valid_reg;
        pend_handler_next = pend_handler_reg;
        strobe_next       = 1'b0;
        result_next       = result_reg;
        wr_en             = 1'b0;
        wr_handler        = rd_handler;
        wr_countdown      = rd_countdown;
        wr_reload         = rd_reload;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    idx_next        = '0;
                    status_next     = STATUS_OK;
                    pend_valid_next = 1'b0;
                    case (cmd.func)
                        FUNC_SET:    state_next = ST_FIND;
                        FUNC_REMOVE: state_next = ST_FIND;
                        FUNC_TICK:   state_next = ST_TICK;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end

            ST_FIND:
            begin
                if (at_end)
                begin
                    // No match: append on set if there is room, else report full; report on remove
                    state_next = ST_FINISH;
                    if (cmd_reg.func == FUNC_SET)
                    begin
                        if (count_reg < SLOTS_CNT)
                        begin
                            wr_en        = 1'b1;
                            wr_handler   = cmd_reg.handler_id;
                            wr_countdown = cmd_reg.delay;
                            wr_reload    = cmd_reg.delay;
                            count_next   = count_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                else if (rd_handler == cmd_reg.handler_id)
                begin
                    if (cmd_reg.func == FUNC_SET)
                    begin
                        wr_en        = 1'b1;
                        wr_countdown = cmd_reg.delay;
                        wr_reload    = cmd_reg.delay;
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else
                begin
                    idx_next = idx_plus;
                end
            end

            ST_SHIFT:
            begin
                // Move later slots down by one, then drop the tail
                if (idx_plus < count_reg)
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_plus;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_FINISH;
                end
            end

            ST_TICK:
            begin
                if (at_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    wr_en    = 1'b1;
                    idx_next = idx_plus;
                    if (rd_countdown != 32'd0)
                    begin
                        wr_countdown = rd_countdown - 32'd1;
                    end
                    else
                    begin
                        // Fired: issue the held beat, hold this one back
                        wr_countdown = rd_reload;
                        if (pend_valid_reg)
                        begin
                            strobe_next               = 1'b1;
                            result_next.status        = STATUS_OK;
                            result_next.fired         = 1'b1;
                            result_next.fired_handler = pend_handler_reg;
                            result_next.last          = 1'b0;
                        end
                        pend_valid_next   = 1'b1;
                        pend_handler_next = rd_handler;
                    end
                end
            end

            ST_FINISH:
            begin
                strobe_next               = 1'b1;
                result_next.status        = status_reg;
                result_next.fired         = pend_valid_reg;
                result_next.fired_handler = pend_valid_reg ? pend_handler_reg : 8'd0;
                result_next.last          = 1'b1;
                state_next                = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        status_reg       <= status_next;
        pend_handler_reg <= pend_handler_next;
        result_reg       <= result_next;
    end

    // Table write port, at the walk index
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_handler_reg[idx_reg[IDX_W-1:0]]   <= wr_handler;
            slot_countdown_reg[idx_reg[IDX_W-1:0]] <= wr_countdown;
            slot_reload_reg[idx_reg[IDX_W-1:0]]    <= wr_reload;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

`default_nettype wire

FILE: test/periodic_timer_table_checker.sv
// Checker for the periodic timer table: predicts every result beat and compares it.
`timescale 1ns / 1ps

module periodic_timer_table_checker
    import ptt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire cmd_t    cmd,
    input  wire logic    result_strobe,
    input  wire result_t result,
    output int           fail_count,
    output int           reports_pending
);

    // Shadow copy of the timer table
    logic        slot_used   [SLOTS];
    logic [7:0]  slot_id     [SLOTS];
    logic [31:0] slot_count  [SLOTS];
    logic [31:0] slot_period [SLOTS];
    int          timers_held;

    // Result beats predicted but not yet seen, oldest first
    result_t     timer_reports_q[$];
    result_t     want;
    int          mismatches = 0;
    int          waiting_beats = 0;

    assign fail_count      = mismatches;
    assign reports_pending = waiting_beats;

    // Update the shadow table for one command and queue the beats it causes
    task automatic apply_timer_cmd(input cmd_t c);
        int      hit;
        int      last_fire;
        result_t beat;
        hit       = -1;
        last_fire = -1;
        beat      = '0;
        beat.status = STATUS_OK;
        beat.last   = 1'b1;
        for (int i = 0; i < timers_held; i++)
        begin
            if (slot_used[i] && slot_id[i] == c.handler_id && hit < 0)
                hit = i;
        end
        case (c.func)
            FUNC_SET:
            begin
                if (hit >= 0)
                begin
                    slot_count[hit]  = c.delay;
                    slot_period[hit] = c.delay;
                end
                else if (timers_held < SLOTS)
                begin
                    slot_used[timers_held]   = 1'b1;
                    slot_id[timers_held]     = c.handler_id;
                    slot_count[timers_held]  = c.delay;
                    slot_period[timers_held] = c.delay;
                    timers_held++;
                end
                else
                begin
                    beat.status = STATUS_FULL;
                end
                timer_reports_q.push_back(beat);
            end
            FUNC_REMOVE:
            begin
                if (hit < 0)
                begin
                    beat.status = STATUS_NOT_FOUND;
                end
                else
                begin
                    // Compact: pull later slots down by one
                    for (int i = hit; i + 1 < timers_held; i++)
                    begin
                        slot_used[i]   = slot_used[i + 1];
                        slot_id[i]     = slot_id[i + 1];
                        slot_count[i]  = slot_count[i + 1];
                        slot_period[i] = slot_period[i + 1];
                    end
                    timers_held--;
                    slot_used[timers_held]   = 1'b0;
                    slot_id[timers_held]     = '0;
                    slot_count[timers_held]  = '0;
                    slot_period[timers_held] = '0;
                end
                timer_reports_q.push_back(beat);
            end
            FUNC_TICK:
            begin
                // Find the final expiring slot so its beat carries last
                for (int i = 0; i < timers_held; i++)
                begin
                    if (slot_used[i] && slot_count[i] == 0)
                        last_fire = i;
                end
                if (last_fire < 0)
                    timer_reports_q.push_back(beat);
                for (int i = 0; i < timers_held; i++)
                begin
                    if (slot_used[i])
                    begin
                        if (slot_count[i] != 0)
                        begin
                            slot_count[i] = slot_count[i] - 1;
                        end
                        else
                        begin
                            beat.fired         = 1'b1;
                            beat.fired_handler = slot_id[i];
                            beat.last          = (i == last_fire);
                            timer_reports_q.push_back(beat);
                            slot_count[i] = slot_period[i];
                        end
                    end
                end
            end
            default:
            begin
                timer_reports_q.push_back(beat);
            end
        endcase
    endtask

    // Compare the result beat first, then take the command beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i]   = 1'b0;
                slot_id[i]     = '0;
                slot_count[i]  = '0;
                slot_period[i] = '0;
            end
            timers_held = 0;
            timer_reports_q.delete();
        end
        else
        begin
            if (result_strobe)
            begin
                if (timer_reports_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat status=%0d fired=%0d id=%02h last=%0d",
                             $time, result.status, result.fired, result.fired_handler,
                             result.last);
                end
                else
                begin
                    want = timer_reports_q.pop_front();
                    if (result.status !== want.status || result.fired !== want.fired ||
                        result.fired_handler !== want.fired_handler ||
                        result.last !== want.last)
                    begin
                        mismatches++;
                        $display("%0t: result mismatch, expected status=%0d fired=%0d id=%02h last=%0d",
                                 $time, want.status, want.fired, want.fired_handler, want.last);
                        $display("%0t:                  actual   status=%0d fired=%0d id=%02h last=%0d",
                                 $time, result.status, result.fired, result.fired_handler,
                                 result.last);
                    end
                end
            end
            if (start && !busy)
                apply_timer_cmd(cmd);
        end
        waiting_beats = timer_reports_q.size();
    end

endmodule

FILE: test/tb_periodic_timer_table_top.sv
// Testbench top for the periodic timer table: command stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_periodic_timer_table_top
    import ptt_pkg::*;
();

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 2 * SLOTS + 4;
    localparam int         RANDOM_BEATS   = 75;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd_beat;
    logic    result_strobe;
    result_t result_beat;
    logic    cmd_taken;
    logic    driving;
    int      burst_left;
    int      idle_cycles = 0;
    int      fail_count;
    int      reports_pending;

    periodic_timer_table_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd_beat),
        .result_strobe (result_strobe),
        .result        (result_beat)
    );

    periodic_timer_table_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd_beat),
        .result_strobe   (result_strobe),
        .result          (result_beat),
        .fail_count      (fail_count),
        .reports_pending (reports_pending)
    );

    // Toggle the clock every half period
    always #5 clk = ~clk;

    // Record whether the command beat was taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_taken <= 1'b0;
        else
            cmd_taken <= start && !busy;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_periodic_timer_table_top NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one command beat, hold it until taken, then maybe idle between bursts
    task automatic issue(input logic [1:0] f, input logic [7:0] id, input logic [31:0] dly);
        cmd_t c;
        cmd_t junk;
        c.func       = f;
        c.handler_id = id;
        c.delay      = dly;
        start    <= 1'b1;
        cmd_beat <= c;
        driving   = 1'b1;
        do
            @(negedge clk);
        while (!cmd_taken);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 9);
            if ($urandom_range(0, 3) != 0)
            begin
                junk.func       = 2'($urandom);
                junk.handler_id = 8'($urandom);
                junk.delay      = $urandom;
                start    <= 1'b0;
                cmd_beat <= junk;
                driving   = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
    endtask

    // Pick a random command, biased toward a small id pool and short delays
    task automatic issue_random();
        int          pick;
        logic [1:0]  f;
        logic [7:0]  id;
        logic [31:0] dly;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f = FUNC_TICK;
        else if (pick < 75)
            f = FUNC_SET;
        else if (pick < 95)
            f = FUNC_REMOVE;
        else
            f = FUNC_UNUSED;
        if ($urandom_range(0, 9) < 7)
            id = 8'($urandom_range(0, 11));
        else
            id = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            dly = $urandom_range(0, 3);
        else if (pick < 85)
            dly = $urandom_range(4, 20);
        else
            dly = $urandom;
        issue(f, id, dly);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd_beat   = '0;
        driving    = 1'b0;
        burst_left = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: tick, remove of an absent id, unused code
        issue(FUNC_TICK,   8'h00, 32'h0);
        issue(FUNC_REMOVE, 8'h00, 32'h0);
        issue(FUNC_UNUSED, 8'h00, 32'h0);
        // Extreme ids and delays, id zero is an ordinary id
        issue(FUNC_SET,    8'h00, 32'h0);
        issue(FUNC_SET,    8'hFF, 32'hFFFF_FFFF);
        issue(FUNC_SET,    8'h5A, 32'h1);
        issue(FUNC_TICK,   8'h00, 32'h0);
        issue(FUNC_TICK,   8'h00, 32'h0);
        // Update an existing timer, then fill the table
        issue(FUNC_SET,    8'h5A, 32'h0);
        for (int i = 1; i <= 5; i++)
            issue(FUNC_SET, 8'(i), 32'h0);
        // Table full: new id refused, existing id still updated
        issue(FUNC_SET,    8'h77, 32'h3);
        issue(FUNC_SET,    8'hFF, 32'h0);
        // Every slot expires on one tick
        issue(FUNC_TICK,   8'h00, 32'h0);
        // Remove from the middle, the front and the end, then an absent id
        issue(FUNC_REMOVE, 8'h5A, 32'h0);
        issue(FUNC_REMOVE, 8'h00, 32'h0);
        issue(FUNC_REMOVE, 8'h05, 32'h0);
        issue(FUNC_REMOVE, 8'h5A, 32'h0);
        issue(FUNC_TICK,   8'h00, 32'h0);
        issue(FUNC_UNUSED, 8'hA5, 32'h5555_AAAA);
        issue(FUNC_SET,    8'h33, 32'hAAAA_5555);
        issue(FUNC_TICK,   8'h00, 32'h0);

        for (int n = 0; n < RANDOM_BEATS; n++)
            issue_random();

        if (driving)
            start <= 1'b0;

        // Drain outstanding results, then allow for late extra beats
        wait (reports_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && reports_pending == 0)
            $display("tb_periodic_timer_table_top OK");
        else
            $display("tb_periodic_timer_table_top NOT OK");
        $finish;
    end

endmodule
